// ----- sv/cd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cd_pkg
// Types and constants shared by the complex divider modules.
// ----------------------------------------------------------------------------
package cd_pkg;

  localparam int DATA_WIDTH = 16;
  localparam int FRAC_BITS  = 16;
  localparam int OUT_W      = 48;

  // product, numerator, magnitude, divisor, dividend and saturation widths
  localparam int PROD_W = 2 * DATA_WIDTH;
  localparam int NUM_W  = 2 * DATA_WIDTH + 1;
  localparam int MAG_W  = 2 * DATA_WIDTH;
  localparam int DIV_W  = 2 * DATA_WIDTH;
  localparam int DVD_W  = MAG_W + FRAC_BITS;
  localparam int SAT_W  = ((DVD_W > OUT_W) ? DVD_W : OUT_W) + 1;

  // accept edge to result strobe, in cycles
  localparam int LATENCY = DVD_W + 4;

  localparam logic [SAT_W-1:0] NEG_LIM = SAT_W'(1) << (OUT_W - 1);
  localparam logic [SAT_W-1:0] POS_LIM = NEG_LIM - SAT_W'(1);

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] num_real;
    logic signed [DATA_WIDTH-1:0] num_imag;
    logic signed [DATA_WIDTH-1:0] den_real;
    logic signed [DATA_WIDTH-1:0] den_imag;
  } operand_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] quotient_real;
    logic signed [OUT_W-1:0] quotient_imag;
    logic                    divide_by_zero;
  } result_t;

  typedef struct packed {
    logic [DVD_W-1:0] dvd;
    logic [DVD_W-1:0] quo;
    logic [DIV_W-1:0] rem;
    logic             neg;
  } lane_t;

  typedef struct packed {
    logic             valid;
    logic             dz;
    logic [DIV_W-1:0] den;
    lane_t            re;
    lane_t            im;
  } cell_t;

endpackage
`default_nettype wire

// ----- sv/cd_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cd_front
// Operand register, products, and numerator / magnitude sums feeding the
// divider chain.
// ----------------------------------------------------------------------------
module cd_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire cd_pkg::operand_t operand,
  output cd_pkg::cell_t         head
);

  cd_pkg::operand_t op;
  logic             v1;
  logic             v2;
  logic signed [cd_pkg::PROD_W-1:0] p_rr, p_ii, p_ir, p_ri, p_bb, p_cc;

  logic signed [cd_pkg::NUM_W-1:0] nr, ni;
  logic [cd_pkg::DIV_W-1:0]        m;
  logic [cd_pkg::MAG_W-1:0]        mag_r, mag_i;
  cd_pkg::cell_t                   head_next;

  always_ff @(posedge clk) begin
    op <= operand;
    p_rr <= op.num_real * op.den_real;
    p_ii <= op.num_imag * op.den_imag;
    p_ir <= op.num_imag * op.den_real;
    p_ri <= op.num_real * op.den_imag;
    p_bb <= op.den_real * op.den_real;
    p_cc <= op.den_imag * op.den_imag;
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= start;
      v2 <= v1;
    end
  end

  always_comb begin
    nr = cd_pkg::NUM_W'(p_rr) + cd_pkg::NUM_W'(p_ii);
    ni = cd_pkg::NUM_W'(p_ir) - cd_pkg::NUM_W'(p_ri);
    // both squares are non-negative, so the sum fits unsigned
    m  = cd_pkg::DIV_W'(p_bb) + cd_pkg::DIV_W'(p_cc);
    mag_r = nr[cd_pkg::NUM_W-1] ? cd_pkg::MAG_W'(-nr) : cd_pkg::MAG_W'(nr);
    mag_i = ni[cd_pkg::NUM_W-1] ? cd_pkg::MAG_W'(-ni) : cd_pkg::MAG_W'(ni);

    head_next.valid  = v2;
    head_next.dz     = (m == '0);
    head_next.den    = m;
    head_next.re.dvd = cd_pkg::DVD_W'(mag_r) << cd_pkg::FRAC_BITS;
    head_next.re.quo = '0;
    head_next.re.rem = '0;
    head_next.re.neg = nr[cd_pkg::NUM_W-1];
    head_next.im.dvd = cd_pkg::DVD_W'(mag_i) << cd_pkg::FRAC_BITS;
    head_next.im.quo = '0;
    head_next.im.rem = '0;
    head_next.im.neg = ni[cd_pkg::NUM_W-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
    end else begin
      head <= head_next;
    end
  end

endmodule
`default_nettype wire

// ----- sv/cd_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cd_cell
// One restoring-division step for both quotient parts: shifts in one
// dividend bit, subtracts the divisor when it fits, emits one quotient bit.
// ----------------------------------------------------------------------------
module cd_cell (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire cd_pkg::cell_t cin,
  output cd_pkg::cell_t      cout
);

  function automatic cd_pkg::lane_t step(input cd_pkg::lane_t l,
                                         input logic [cd_pkg::DIV_W-1:0] den);
    logic [cd_pkg::DIV_W:0] t;
    logic [cd_pkg::DIV_W:0] d;
    logic [cd_pkg::DIV_W:0] diff;
    logic                   fit;
    cd_pkg::lane_t          o;
    t    = {l.rem, l.dvd[cd_pkg::DVD_W-1]};
    d    = {1'b0, den};
    diff = t - d;
    fit  = (t >= d);
    o.rem = fit ? diff[cd_pkg::DIV_W-1:0] : t[cd_pkg::DIV_W-1:0];
    o.dvd = l.dvd << 1;
    o.quo = {l.quo[cd_pkg::DVD_W-2:0], fit};
    o.neg = l.neg;
    return o;
  endfunction

  cd_pkg::cell_t cout_next;

  always_comb begin
    cout_next    = cin;
    cout_next.re = step(cin.re, cin.den);
    cout_next.im = step(cin.im, cin.den);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cout <= '0;
    end else begin
      cout <= cout_next;
    end
  end

endmodule
`default_nettype wire

// ----- sv/complex_divider.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// complex_divider
// Fixed-point quotient of two complex integers, a * conj(b) / |b|^2,
// truncated toward zero and saturated; zero denominator gives 1.0 + 0j.
// ----------------------------------------------------------------------------
//  channel   ports                      handshake
//  input     start, busy, operand       taken when start && !busy
//  output    done, result               one-cycle strobe, no back-pressure
//
//  a transaction enters every cycle; busy is always low
//  result passes the operand, product and head registers, then the
//  chain of one divider cell per quotient bit, then the result register
//  synchronous reset flushes all in-flight transactions
// ----------------------------------------------------------------------------
module complex_divider (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire cd_pkg::operand_t operand,
  output logic                  done,
  output cd_pkg::result_t       result
);

  function automatic logic [cd_pkg::OUT_W-1:0] sat_out(
      input logic [cd_pkg::DVD_W-1:0] q, input logic neg);
    logic [cd_pkg::SAT_W-1:0] qx;
    logic [cd_pkg::SAT_W-1:0] lim;
    qx  = cd_pkg::SAT_W'(q);
    lim = neg ? cd_pkg::NEG_LIM : cd_pkg::POS_LIM;
    if (qx > lim) begin
      qx = lim;
    end
    if (neg) begin
      qx = -qx;
    end
    return qx[cd_pkg::OUT_W-1:0];
  endfunction

  cd_pkg::cell_t   chain [0:cd_pkg::DVD_W];
  cd_pkg::cell_t   tail;
  cd_pkg::result_t result_next;

  assign busy = 1'b0;

  cd_front u_front (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .operand (operand),
    .head    (chain[0])
  );

  for (genvar k = 0; k < cd_pkg::DVD_W; k++) begin : g_cell
    cd_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .cin  (chain[k]),
      .cout (chain[k+1])
    );
  end

  assign tail = chain[cd_pkg::DVD_W];

  always_comb begin
    if (tail.dz) begin
      result_next.quotient_real  = cd_pkg::OUT_W'(1) << cd_pkg::FRAC_BITS;
      result_next.quotient_imag  = '0;
      result_next.divide_by_zero = 1'b1;
    end else begin
      result_next.quotient_real  = sat_out(tail.re.quo, tail.re.neg);
      result_next.quotient_imag  = sat_out(tail.im.quo, tail.im.neg);
      result_next.divide_by_zero = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= tail.valid;
    end
  end

endmodule
`default_nettype wire

// ----- sv/cd_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cd_checker
// Port-level checks on the complex divider, bound to the top level.
// ----------------------------------------------------------------------------
module cd_checker (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             start,
  input wire logic             busy,
  input wire logic             done,
  input wire cd_pkg::result_t  result
);

  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##(cd_pkg::LATENCY) done)
    else $error("accepted transaction produced no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, cd_pkg::LATENCY))
    else $error("result without a matching transaction");

  a_dz_value: assert property (@(posedge clk) disable iff (rst)
    (done && result.divide_by_zero) |->
      (result.quotient_imag == '0) &&
      (result.quotient_real == (cd_pkg::OUT_W'(1) << cd_pkg::FRAC_BITS)))
    else $error("zero denominator result is not one");

endmodule

bind complex_divider cd_checker u_cd_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .done    (done),
  .result  (result)
);
`default_nettype wire
